// ===== hw/rtl/edmf_pkg.sv =====
// Package for the echo distance mode filter: widths, register indexes,
// divide-by-58 constants, queue write struct, back-end state type, blink map.
// No dependencies.
package edmf_pkg;

    localparam int WIDTH_W    = 16;
    localparam int DIST_W     = 9;
    localparam int BLINK_W    = 10;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_DIST = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DIST = 1'b1;

    localparam logic [DIST_W-1:0] MIN_DIST_RST = 9'd2;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 9'd400;

    // floor((w + 29) / 58) as ((w + 29) * ceil(2^22 / 58)) >> 22, exact for w < 2^16
    localparam int RAW_W     = WIDTH_W + 1;
    localparam int PROD_W    = 2 * RAW_W;
    localparam int DIV_SHIFT = 22;
    localparam int QUOT_W    = 11;
    localparam logic [RAW_W-1:0] ROUND_ADD = 17'd29;
    localparam logic [RAW_W-1:0] RECIP_58  = 17'd72316;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QCNT_W      = 2;

    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [BLINK_W-1:0] blink_t;

    typedef struct packed {
        logic  req;
        dist_t sample;
    } q_wr_t;

    typedef enum logic [1:0] {
        BK_TAKE,
        BK_SCAN,
        BK_HOLD
    } back_state_t;

    function automatic blink_t blink_for(dist_t d);
        blink_t b;
        if (d < 9'd10)
            b = 10'd0;
        else if (d < 9'd25)
            b = 10'd200;
        else if (d < 9'd50)
            b = 10'd300;
        else if (d < 9'd75)
            b = 10'd400;
        else if (d < 9'd100)
            b = 10'd500;
        else
            b = 10'd1000;
        return b;
    endfunction

endpackage

// ===== hw/rtl/echo_distance_mode_filter_unit.sv =====
// Top level of the echo distance mode filter: front end, distance queue, back end.
// Depends on edmf_pkg, edmf_front, edmf_queue, edmf_back.
//
// channel   ports                                   request when
// input     push, full, echo_width_us               push && !full
// result    empty, pop, distance_cm, blink_...      pop && !empty
// config    cfg_we, cfg_addr, cfg_wdata             cfg_we
//
// Front takes one width per cycle while full is low; the distance is ready in the next cycle (one multiply).
// A valid sample that arrives while the window is not full is only stored.
// A sample that arrives while it is full is stored in slot 0, then the mode is
// counted slot by slot, then the result register is loaded once it is free.
// full rises only when the two-entry queue is full and the front holds a valid sample.
// Reset is asynchronous; window contents are not cleared, the fill position is.
module echo_distance_mode_filter_unit
    import edmf_pkg::*;
#(
    parameter int WINDOW_LEN = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [WIDTH_W-1:0]    echo_width_us,
    output logic                  empty,
    input  logic                  pop,
    output logic [DIST_W-1:0]     distance_cm,
    output logic [BLINK_W-1:0]    blink_half_period_ms,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DIST_W-1:0]     cfg_wdata
);

    q_wr_t q_wr;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    dist_t q_dist;

    edmf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .echo_width_us (echo_width_us),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .q_wr          (q_wr),
        .q_full        (q_full)
    );

    edmf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .full     (q_full),
        .rd_pop   (q_pop),
        .rd_empty (q_empty),
        .rd_dist  (q_dist)
    );

    edmf_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .q_empty              (q_empty),
        .q_dist               (q_dist),
        .q_pop                (q_pop),
        .empty                (empty),
        .pop                  (pop),
        .distance_cm          (distance_cm),
        .blink_half_period_ms (blink_half_period_ms)
    );

endmodule

// ===== hw/rtl/edmf_front.sv =====
// Front end: accepts echo widths, converts to cm, range-checks against the
// configuration registers and requests valid distances into the queue.
// Depends on edmf_pkg.
module edmf_front
    import edmf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [WIDTH_W-1:0]    echo_width_us,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DIST_W-1:0]     cfg_wdata,
    output q_wr_t                 q_wr,
    input  logic                  q_full
);

    dist_t              min_reg;
    dist_t              max_reg;
    logic               vld_reg;
    logic               vld_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [RAW_W-1:0]   raw;
    logic [QUOT_W-1:0]  quot;
    logic               in_range;
    logic               stall;
    logic               accept;

    assign raw       = RAW_W'(echo_width_us) + ROUND_ADD;
    assign prod_next = PROD_W'(raw) * PROD_W'(RECIP_58);
    assign quot      = prod_reg[DIV_SHIFT +: QUOT_W];
    assign in_range  = (quot >= QUOT_W'(min_reg)) && (quot <= QUOT_W'(max_reg));
    assign stall     = vld_reg && in_range && q_full;
    assign full      = stall;
    assign accept    = push && !full;
    assign vld_next  = accept || stall;

    assign q_wr.req    = vld_reg && in_range && !q_full;
    assign q_wr.sample = quot[DIST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            min_reg <= MIN_DIST_RST;
            max_reg <= MAX_DIST_RST;
        end
        else
        begin
            vld_reg <= vld_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_MIN_DIST: min_reg <= cfg_wdata;
                    REG_MAX_DIST: max_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            prod_reg <= prod_next;
    end

endmodule

// ===== hw/rtl/edmf_queue.sv =====
// Short distance queue between front and back end.
// Depends on edmf_pkg.
module edmf_queue
    import edmf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  q_wr_t wr,
    output logic  full,
    input  logic  rd_pop,
    output logic  rd_empty,
    output dist_t rd_dist
);

    dist_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]    cnt_reg;
    logic                 do_wr;
    logic                 do_rd;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_empty = (cnt_reg == '0);
    assign rd_dist  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr.req && !full;
    assign do_rd    = rd_pop && !rd_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr.sample;
    end

endmodule

// ===== hw/rtl/edmf_back.sv =====
// Back end: sample window, fill position, slot-by-slot mode scan,
// blink mapping and the result register.
// Depends on edmf_pkg.
module edmf_back
    import edmf_pkg::*;
#(
    parameter int WINDOW_LEN = 5
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_empty,
    input  dist_t  q_dist,
    output logic   q_pop,
    output logic   empty,
    input  logic   pop,
    output dist_t  distance_cm,
    output blink_t blink_half_period_ms
);

    localparam int POS_W = $clog2(WINDOW_LEN + 1);
    localparam int IDX_W = $clog2(WINDOW_LEN);
    localparam logic [POS_W-1:0] POS_FULL = POS_W'(WINDOW_LEN);
    localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_LEN - 1);

    dist_t               win_reg [WINDOW_LEN];
    logic [IDX_W-1:0]    win_idx;
    logic                win_we;

    back_state_t         state_reg, state_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [IDX_W-1:0]    scan_reg, scan_next;
    logic [POS_W-1:0]    best_cnt_reg, best_cnt_next;
    dist_t               best_reg, best_next;
    logic [WINDOW_LEN-1:0] match;
    logic [POS_W-1:0]    cnt;

    logic                out_vld_reg, out_vld_next;
    logic                out_load;
    dist_t               out_dist_reg;
    blink_t              out_blink_reg;

    assign win_idx = (pos_reg == POS_FULL) ? '0 : pos_reg[IDX_W-1:0];

    always_comb
    begin
        for (int j = 0; j < WINDOW_LEN; j++)
            match[j] = (win_reg[j] == win_reg[scan_reg]);
    end

    assign cnt = POS_W'($countones(match));

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        scan_next     = scan_reg;
        best_cnt_next = best_cnt_reg;
        best_next     = best_reg;
        q_pop         = 1'b0;
        win_we        = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            BK_TAKE:
            begin
                if (!q_empty)
                begin
                    q_pop  = 1'b1;
                    win_we = 1'b1;
                    if (pos_reg == POS_FULL)
                    begin
                        pos_next      = POS_ONE;
                        scan_next     = '0;
                        best_cnt_next = '0;
                        state_next    = BK_SCAN;
                    end
                    else
                        pos_next = pos_reg + 1'b1;
                end
            end
            BK_SCAN:
            begin
                if (cnt > best_cnt_reg)
                begin
                    best_cnt_next = cnt;
                    best_next     = win_reg[scan_reg];
                end
                if (scan_reg == IDX_LAST)
                    state_next = BK_HOLD;
                else
                    scan_next = scan_reg + 1'b1;
            end
            BK_HOLD:
            begin
                if (!out_vld_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = BK_TAKE;
                end
            end
            default: state_next = BK_TAKE;
        endcase
    end

    assign out_vld_next = out_load || (out_vld_reg && !pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_TAKE;
            pos_reg      <= '0;
            scan_reg     <= '0;
            best_cnt_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            scan_reg     <= scan_next;
            best_cnt_reg <= best_cnt_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        if (win_we)
            win_reg[win_idx] <= q_dist;
        if (out_load)
        begin
            out_dist_reg  <= best_reg;
            out_blink_reg <= blink_for(best_reg);
        end
    end

    assign empty                = !out_vld_reg;
    assign distance_cm          = out_dist_reg;
    assign blink_half_period_ms = out_blink_reg;

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_FULL)
        else $error("fill position past window length");

    a_pos_after_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SCAN || state_reg == BK_HOLD) |-> pos_reg == POS_ONE)
        else $error("fill position not reset by wrap");

    a_scan_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SCAN && scan_reg == IDX_LAST) |=> state_reg == BK_HOLD)
        else $error("scan did not finish into hold");

    a_no_pop_off_take: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == BK_TAKE && !q_empty))
        else $error("queue request outside take state");
`endif

endmodule

// ===== tb/sv/echo_distance_mode_filter_unit_test.sv =====
// Self-checking testbench for echo_distance_mode_filter_unit: directed and random echo
// widths under several distance ranges, mode predicted in a scoreboard class.
// Depends on edmf_pkg and the echo_distance_mode_filter_unit RTL.
`timescale 1ns / 100ps

module echo_distance_mode_filter_unit_test;
    import edmf_pkg::*;

    localparam int WINDOW_LEN  = 5;
    localparam int US_PER_CM   = 58;
    localparam int ROUND_US    = 29;
    localparam int SETTLE      = 4 * (WINDOW_LEN + 3);
    localparam int PHASE_ITEMS = 220;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        dist_t  cm;
        blink_t blink;
    } reading_t;

    class mode_scoreboard;
        dist_t       min_cm;
        dist_t       max_cm;
        dist_t       slots[WINDOW_LEN];
        int unsigned fill;
        reading_t    pending[$];
        int          errors;

        function new();
            min_cm = MIN_DIST_RST;
            max_cm = MAX_DIST_RST;
            fill   = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, dist_t value);
            if (addr == REG_MIN_DIST)
                min_cm = value;
            else if (addr == REG_MAX_DIST)
                max_cm = value;
        endfunction

        function blink_t blink_of(dist_t cm);
            if (cm < 10)
                return 10'd0;
            if (cm < 25)
                return 10'd200;
            if (cm < 50)
                return 10'd300;
            if (cm < 75)
                return 10'd400;
            if (cm < 100)
                return 10'd500;
            return 10'd1000;
        endfunction

        function void note_width(logic [WIDTH_W-1:0] width);
            int unsigned range_cm;
            int unsigned best_n;
            int unsigned n;
            int          best_i;
            reading_t    r;
            range_cm = (32'(width) + ROUND_US) / US_PER_CM;
            if (range_cm < 32'(min_cm) || range_cm > 32'(max_cm))
                return;
            if (fill < WINDOW_LEN)
            begin
                slots[fill] = dist_t'(range_cm);
                fill++;
                return;
            end
            slots[0] = dist_t'(range_cm);
            fill     = 1;
            best_n   = 0;
            best_i   = 0;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                n = 0;
                for (int j = 0; j < WINDOW_LEN; j++)
                    if (slots[j] == slots[i])
                        n++;
                if (n > best_n)
                begin
                    best_n = n;
                    best_i = i;
                end
            end
            r.cm    = slots[best_i];
            r.blink = blink_of(r.cm);
            pending.push_back(r);
        endfunction

        function void check_reading(dist_t cm, blink_t blink);
            reading_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected request distance_cm=%0d blink_half_period_ms=%0d",
                         $time, cm, blink);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (cm !== want.cm)
            begin
                $display("%0t: distance_cm expected %0d actual %0d", $time, want.cm, cm);
                errors++;
            end
            if (blink !== want.blink)
            begin
                $display("%0t: blink_half_period_ms expected %0d actual %0d",
                         $time, want.blink, blink);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [WIDTH_W-1:0]    echo_width_us = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [DIST_W-1:0]     distance_cm;
    logic [BLINK_W-1:0]    blink_half_period_ms;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [DIST_W-1:0]     cfg_wdata = '0;

    mode_scoreboard sb;
    bit             hold_off_req = 1'b0;
    int             send_burst = 0;
    int             pop_burst = 0;
    int             pop_gap;

    echo_distance_mode_filter_unit #(
        .WINDOW_LEN(WINDOW_LEN)
    ) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .push                 (push),
        .full                 (full),
        .echo_width_us        (echo_width_us),
        .empty                (empty),
        .pop                  (pop),
        .distance_cm          (distance_cm),
        .blink_half_period_ms (blink_half_period_ms),
        .cfg_we               (cfg_we),
        .cfg_addr             (cfg_addr),
        .cfg_wdata            (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                sb.check_reading(distance_cm, blink_half_period_ms);
            if (push && !full)
                sb.note_width(echo_width_us);
            if (cfg_we)
                sb.write_reg(cfg_addr, cfg_wdata);
        end
    end

    function automatic int pick_gap(inout int burst_left);
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(99, 0);
        if (r < 2)
        begin
            burst_left = $urandom_range(40, 20);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic int unsigned pick_cm(int unsigned lo, int unsigned hi);
        if (lo <= hi)
            return $urandom_range(hi, lo);
        return $urandom_range(511, 0);
    endfunction

    function automatic int unsigned width_for(int unsigned cm);
        int unsigned w;
        if (cm == 0)
            w = $urandom_range(ROUND_US - 1, 0);
        else
            w = US_PER_CM * cm - ROUND_US + $urandom_range(US_PER_CM - 1, 0);
        if (w > 65535)
            w = 65535;
        return w;
    endfunction

    task automatic push_width(input int unsigned width);
        int gap;
        gap = pick_gap(send_burst);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push          <= 1'b1;
        echo_width_us <= WIDTH_W'(width);
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input dist_t value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_range(input int unsigned lo, input int unsigned hi);
        drain();
        write_reg(REG_MIN_DIST, dist_t'(lo));
        write_reg(REG_MAX_DIST, dist_t'(hi));
    endtask

    // mostly a few recurring distances per stretch so the window sees repeats and ties
    task automatic run_random(input int unsigned lo, input int unsigned hi, input int count);
        int unsigned pool[3];
        int          r;
        for (int k = 0; k < count; k++)
        begin
            if (k % 20 == 0)
                foreach (pool[p])
                    pool[p] = pick_cm(lo, hi);
            r = $urandom_range(99, 0);
            if (r < 75)
                push_width(width_for(pool[$urandom_range(2, 0)]));
            else if (r < 87)
                push_width(width_for(pick_cm(lo, hi)));
            else
                push_width($urandom_range(65535, 0));
        end
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                pop_gap      = LONG_HOLD;
            end
            else
                pop_gap = pick_gap(pop_burst);
            if (pop_gap > 0)
            begin
                pop <= 1'b0;
                repeat (pop_gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
        end
    end

    initial
    begin
        #4_000_000;
        $display("echo_distance_mode_filter_unit_test failed");
        $finish;
    end

    initial
    begin
        int unsigned lo;
        int unsigned hi;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset range: zero width, below min, large width, above max all dropped
        push_width(0);
        push_width(ROUND_US - 1);
        push_width(ROUND_US);
        push_width(65535);
        push_width(US_PER_CM * 401 - ROUND_US);
        // blink band edges
        push_width(US_PER_CM * 9 - ROUND_US);
        push_width(US_PER_CM * 10 + ROUND_US - 1);
        push_width(US_PER_CM * 24 - ROUND_US);
        push_width(US_PER_CM * 25 + ROUND_US - 1);
        push_width(US_PER_CM * 49 - ROUND_US);
        push_width(US_PER_CM * 50 + ROUND_US - 1);
        push_width(US_PER_CM * 74 - ROUND_US);
        push_width(US_PER_CM * 75 + ROUND_US - 1);
        push_width(US_PER_CM * 99 - ROUND_US);
        push_width(US_PER_CM * 100 + ROUND_US - 1);
        push_width(US_PER_CM * 24);
        // range edges, then a clear majority
        push_width(US_PER_CM * 400 - ROUND_US);
        push_width(US_PER_CM * 400 + ROUND_US - 1);
        push_width(US_PER_CM * 2 - ROUND_US);
        push_width(US_PER_CM * 2 + ROUND_US - 1);
        push_width(US_PER_CM * 400);
        // tie between two values: the earlier slot wins
        push_width(US_PER_CM * 99);
        push_width(US_PER_CM * 12 - ROUND_US);
        push_width(US_PER_CM * 99);
        push_width(US_PER_CM * 12 + ROUND_US - 1);
        push_width(US_PER_CM * 100);

        hold_off_req = 1'b1;
        run_random(32'(MIN_DIST_RST), 32'(MAX_DIST_RST), PHASE_ITEMS);

        set_range(0, 511);
        push_width(0);
        push_width(ROUND_US - 1);
        push_width(US_PER_CM * 511 - ROUND_US);
        push_width(US_PER_CM * 511 + ROUND_US - 1);
        push_width(US_PER_CM * 512 - ROUND_US);
        run_random(0, 511, PHASE_ITEMS);

        set_range(511, 511);
        run_random(511, 511, PHASE_ITEMS);

        set_range(0, 0);
        run_random(0, 0, PHASE_ITEMS / 2);

        // empty range: nothing gets into the window
        set_range(300, 100);
        run_random(300, 100, PHASE_ITEMS / 2);

        set_range(0, 15);
        hold_off_req = 1'b1;
        run_random(0, 15, PHASE_ITEMS);

        repeat (2)
        begin
            lo = $urandom_range(200, 0);
            hi = lo + $urandom_range(511 - lo, 0);
            set_range(lo, hi);
            run_random(lo, hi, PHASE_ITEMS);
        end

        drain();
        if (sb.errors == 0)
            $display("echo_distance_mode_filter_unit_test passed");
        else
            $display("echo_distance_mode_filter_unit_test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/edmf_pkg.sv
hw/rtl/edmf_front.sv
hw/rtl/edmf_queue.sv
hw/rtl/edmf_back.sv
hw/rtl/echo_distance_mode_filter_unit.sv
tb/sv/echo_distance_mode_filter_unit_test.sv
